// ===== rtl/core/icaf_pkg.sv =====
package icaf_pkg;

  localparam int HalfTurn   = 11520;
  localparam int FullTurn   = 23040;
  localparam int PitchLimit = 5120;

  localparam logic [2:0] RegBiasX = 3'd0;
  localparam logic [2:0] RegBiasY = 3'd1;
  localparam logic [2:0] RegBiasZ = 3'd2;
  localparam logic [2:0] RegGain  = 3'd3;
  localparam logic [2:0] RegAlpha = 3'd4;
  localparam logic [2:0] RegOneG  = 3'd5;

  // CORDIC angle table, 2^-16 of 1/64 deg
  function automatic logic [28:0] atan_lut(input logic [4:0] i);
    case (i)
      5'd0:  atan_lut = 29'd188743680;
      5'd1:  atan_lut = 29'd111421900;
      5'd2:  atan_lut = 29'd58872272;
      5'd3:  atan_lut = 29'd29884485;
      5'd4:  atan_lut = 29'd15000234;
      5'd5:  atan_lut = 29'd7507429;
      5'd6:  atan_lut = 29'd3754631;
      5'd7:  atan_lut = 29'd1877430;
      5'd8:  atan_lut = 29'd938729;
      5'd9:  atan_lut = 29'd469366;
      5'd10: atan_lut = 29'd234683;
      5'd11: atan_lut = 29'd117342;
      5'd12: atan_lut = 29'd58671;
      5'd13: atan_lut = 29'd29335;
      5'd14: atan_lut = 29'd14668;
      5'd15: atan_lut = 29'd7334;
      5'd16: atan_lut = 29'd3667;
      5'd17: atan_lut = 29'd1833;
      5'd18: atan_lut = 29'd917;
      5'd19: atan_lut = 29'd458;
      5'd20: atan_lut = 29'd229;
      5'd21: atan_lut = 29'd115;
      5'd22: atan_lut = 29'd57;
      5'd23: atan_lut = 29'd29;
      default: atan_lut = '0;
    endcase
  endfunction

  typedef enum logic [10:0] {
    StIdle   = 11'b00000000001,
    StPrep   = 11'b00000000010,
    StSqrt   = 11'b00000000100,
    StCorIn  = 11'b00000001000,
    StCorIt  = 11'b00000010000,
    StCorEnd = 11'b00000100000,
    StMul    = 11'b00001000000,
    StBlend  = 11'b00010000000,
    StWrap   = 11'b00100000000,
    StDone   = 11'b01000000000,
    StOut    = 11'b10000000000
  } state_e;

endpackage

// ===== rtl/core/imu_complementary_attitude_filter_top.sv =====
// Complementary attitude filter. One word in, one word out. A sample goes from
// accept to result word through a 32-step bit-pair square root, two CORDIC
// atan2 runs of NSteps iterations each (steps are capped at 24) through one
// shared shift/add unit, then sequenced multiplies (one 18x33 multiplier
// shared) for the gyro step, magnitude test and blend, and the wrap, store
// and present states; the first sample after reset seeds the estimates from
// the accelerometer angles without blend or wrap. A reset command gives its
// word in the cycle after accept. in_stall_o is high while a sample is in
// work or its result is still waiting.
module imu_complementary_attitude_filter_top
  import icaf_pkg::*;
#(
  parameter int CORDIC_STEPS = 16,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic signed [15:0] gyro_x_i,
  input  logic signed [15:0] gyro_y_i,
  input  logic signed [15:0] gyro_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [14:0] roll_angle_o,
  output logic signed [14:0] pitch_angle_o,
  output logic        [14:0] yaw_angle_o,
  output logic signed [15:0] rate_x_o,
  output logic signed [15:0] rate_y_o,
  output logic signed [15:0] rate_z_o,
  output logic               blend_applied_o,
  output logic               seeded_o
);

  localparam int NSteps = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int CW = 40; // cordic datapath width

  // configuration
  logic signed [15:0] bias_x_q, bias_y_q, bias_z_q;
  logic [15:0] gain_q, alpha_q;
  logic [14:0] oneg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_x_q <= '0; bias_y_q <= '0; bias_z_q <= '0;
      gain_q <= 16'd2621; alpha_q <= 16'd64225; oneg_q <= 15'd981;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegBiasX: bias_x_q <= cfg_data_i;
        RegBiasY: bias_y_q <= cfg_data_i;
        RegBiasZ: bias_z_q <= cfg_data_i;
        RegGain:  gain_q   <= cfg_data_i;
        RegAlpha: alpha_q  <= cfg_data_i;
        RegOneG:  oneg_q   <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  function automatic logic signed [15:0] sx(input logic [15:0] v);
    logic [15:0] s;
    s = v << (16 - SAMPLE_BITS);
    sx = $signed(s) >>> (16 - SAMPLE_BITS);
  endfunction

  function automatic logic signed [15:0] sat(input logic signed [16:0] v);
    if (v > 17'sd32767) sat = 16'sh7fff;
    else if (v < -17'sd32768) sat = 16'sh8000;
    else sat = v[15:0];
  endfunction

  state_e st_q;
  logic signed [15:0] ax_q, ay_q, az_q, rx_q, ry_q, rz_q;
  logic signed [31:0] roll_q, pitch_q, yaw_q; // estimates
  logic ready_q;
  // work registers
  logic signed [31:0] racc_q, pacc_q, r_q, p_q, y_q;
  logic [63:0] sq_v_q;
  logic [63:0] sq_r_q;
  logic [5:0]  cnt_q;
  logic signed [CW-1:0] cx_q, cy_q;
  logic signed [31:0] cz_q;
  logic pass_q, zero_q, blended_q, seeded_q;
  logic signed [50:0] acc_q;   // multiplier accumulate
  logic [4:0] mstep_q;
  logic out_valid_q;
  logic signed [14:0] o_roll_q, o_pitch_q;
  logic [14:0] o_yaw_q;
  logic signed [15:0] o_rx_q, o_ry_q, o_rz_q;
  logic o_bl_q, o_sd_q;

  logic accept;
  assign in_stall_o = (st_q != StIdle) || out_valid_q;
  assign accept = in_valid_i && !in_stall_o;

  // shared multiplier: signed 18 x signed 33
  logic signed [17:0] ma;
  logic signed [32:0] mb;
  logic signed [50:0] mp;
  assign mp = ma * mb;

  // isqrt step: sqrt((ay^2+az^2)<<32), bit from 2^62 down
  logic [63:0] sq_bit;
  logic [64:0] sq_t;
  assign sq_bit = 64'd1 << {cnt_q, 1'b0};
  assign sq_t = {1'b0, sq_v_q} - ({1'b0, sq_r_q} + {1'b0, sq_bit});

  // cordic step
  logic signed [CW-1:0] xs, ys;
  logic [4:0] ci;
  assign ci = cnt_q[4:0];
  assign xs = cx_q >>> ci;
  assign ys = cy_q >>> ci;

  // rounded z
  logic signed [31:0] zr;
  assign zr = (cz_q + 32'sd32768) >>> 16;

  // magnitude window
  logic [33:0] m2_q, g2_q;
  logic [41:0] m100, g49, g169;
  assign m100 = {8'd0, m2_q} * 42'd100;
  assign g49  = {8'd0, g2_q} * 42'd49;
  assign g169 = {8'd0, g2_q} * 42'd169;

  function automatic logic signed [31:0] wrapa(input logic signed [31:0] v, input logic yawm);
    logic signed [31:0] hi, lo, w;
    hi = yawm ? 32'sd23040 : 32'sd11520;
    lo = yawm ? 32'sd0 : -32'sd11520;
    w = v;
    for (int k = 0; k < 2; k++) begin
      if (w > hi) w = w - 32'sd23040;
      else if (w < lo) w = w + 32'sd23040;
    end
    wrapa = w;
  endfunction

  always_comb begin
    ma = '0; mb = '0;
    case (mstep_q)
      5'd0: begin ma = 18'(rx_q); mb = 33'(gain_q); end
      5'd1: begin ma = 18'(ry_q); mb = 33'(gain_q); end
      5'd2: begin ma = 18'(rz_q); mb = 33'(gain_q); end
      5'd3: begin ma = 18'(ax_q); mb = 33'(ax_q); end
      5'd4: begin ma = 18'(ay_q); mb = 33'(ay_q); end
      5'd5: begin ma = 18'(az_q); mb = 33'(az_q); end
      5'd6: begin ma = 18'({1'b0, oneg_q}); mb = 33'({1'b0, oneg_q}); end
      5'd7: begin ma = 18'({1'b0, alpha_q}); mb = 33'(r_q); end
      5'd8: begin ma = 18'sd65536 - $signed({2'b0, alpha_q}); mb = 33'(racc_q); end
      5'd9: begin ma = 18'({1'b0, alpha_q}); mb = 33'(p_q); end
      5'd10: begin ma = 18'sd65536 - $signed({2'b0, alpha_q}); mb = 33'(pacc_q); end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      ready_q <= 1'b0;
      roll_q <= '0; pitch_q <= '0; yaw_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (st_q)
        StIdle: if (accept) begin
          if (command_i) begin
            roll_q <= '0; pitch_q <= '0; yaw_q <= '0; ready_q <= 1'b0;
            o_roll_q <= '0; o_pitch_q <= '0; o_yaw_q <= '0;
            o_rx_q <= '0; o_ry_q <= '0; o_rz_q <= '0;
            o_bl_q <= 1'b0; o_sd_q <= 1'b0;
            out_valid_q <= 1'b1;
          end else begin
            ax_q <= sx(accel_x_i); ay_q <= sx(accel_y_i); az_q <= sx(accel_z_i);
            rx_q <= sat(17'(sx(gyro_x_i)) - 17'(bias_x_q));
            ry_q <= sat(17'(sx(gyro_y_i)) - 17'(bias_y_q));
            rz_q <= sat(17'(sx(gyro_z_i)) - 17'(bias_z_q));
            st_q <= StPrep;
          end
        end
        StPrep: begin
          sq_v_q <= 64'(unsigned'(32'(ay_q * ay_q) + 32'(az_q * az_q))) << 32;
          sq_r_q <= '0;
          cnt_q <= 6'd31;
          st_q <= StSqrt;
        end
        StSqrt: begin
          if (!sq_t[64]) begin
            sq_v_q <= sq_t[63:0];
            sq_r_q <= (sq_r_q >> 1) + sq_bit;
          end else begin
            sq_r_q <= sq_r_q >> 1;
          end
          if (cnt_q == 6'd0) begin
            pass_q <= 1'b0;
            st_q <= StCorIn;
          end
          cnt_q <= cnt_q - 6'd1;
        end
        StCorIn: begin
          logic signed [CW-1:0] x0, y0;
          x0 = pass_q ? CW'($signed({1'b0, sq_r_q[32:0]})) : CW'(az_q) <<< 16;
          y0 = pass_q ? CW'(ax_q) <<< 16 : CW'(ay_q) <<< 16;
          zero_q <= (x0 == '0) && (y0 == '0);
          cnt_q <= '0;
          if (x0 < 0) begin
            if (y0 >= 0) begin
              cx_q <= y0; cy_q <= -x0; cz_q <= 32'sd377487360;
            end else begin
              cx_q <= -y0; cy_q <= x0; cz_q <= -32'sd377487360;
            end
          end else begin
            cx_q <= x0; cy_q <= y0; cz_q <= '0;
          end
          st_q <= StCorIt;
        end
        StCorIt: begin
          if (cy_q > 0) begin
            cx_q <= cx_q + ys; cy_q <= cy_q - xs;
            cz_q <= cz_q + $signed({3'b0, atan_lut(ci)});
          end else begin
            cx_q <= cx_q - ys; cy_q <= cy_q + xs;
            cz_q <= cz_q - $signed({3'b0, atan_lut(ci)});
          end
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(NSteps - 1)) st_q <= StCorEnd;
        end
        StCorEnd: begin
          logic signed [31:0] a;
          a = zero_q ? 32'sd0 : (zr > HalfTurn) ? 32'sd11520 :
              (zr < -HalfTurn) ? -32'sd11520 : zr;
          if (!pass_q) begin
            racc_q <= a; pass_q <= 1'b1; st_q <= StCorIn;
          end else begin
            pacc_q <= a;
            mstep_q <= '0; acc_q <= '0; m2_q <= '0;
            blended_q <= 1'b0;
            st_q <= StMul;
          end
        end
        StMul: begin
          // one product per cycle
          case (mstep_q)
            5'd0: r_q <= roll_q + 32'((mp + 51'sd32768) >>> 16);
            5'd1: p_q <= pitch_q + 32'((mp + 51'sd32768) >>> 16);
            5'd2: y_q <= yaw_q + 32'((mp + 51'sd32768) >>> 16);
            5'd3, 5'd4, 5'd5: m2_q <= m2_q + 34'(mp);
            default: g2_q <= 34'(mp);
          endcase
          mstep_q <= mstep_q + 5'd1;
          if (mstep_q == 5'd6) st_q <= StBlend;
        end
        StBlend: begin
          if (!ready_q) begin
            r_q <= racc_q; p_q <= pacc_q; y_q <= '0;
            st_q <= StDone;
          end else if (mstep_q == 5'd7) begin
            if (m100 > g49 && m100 < g169) begin
              blended_q <= 1'b1; acc_q <= mp; mstep_q <= 5'd8;
            end else st_q <= StWrap;
          end else if (mstep_q == 5'd8) begin
            r_q <= 32'((acc_q + mp + 51'sd32768) >>> 16);
            if (p_q < PitchLimit && p_q > -PitchLimit) mstep_q <= 5'd9;
            else st_q <= StWrap;
          end else if (mstep_q == 5'd9) begin
            acc_q <= mp; mstep_q <= 5'd10;
          end else begin
            p_q <= 32'((acc_q + mp + 51'sd32768) >>> 16);
            st_q <= StWrap;
          end
        end
        StWrap: begin
          // one gyro step moves an angle by less than one and a half turns
          r_q <= wrapa(r_q, 1'b0);
          p_q <= wrapa(p_q, 1'b0);
          y_q <= wrapa(y_q, 1'b1);
          st_q <= StDone;
        end
        StDone: begin
          roll_q <= r_q; pitch_q <= p_q; yaw_q <= y_q;
          seeded_q <= !ready_q;
          ready_q <= 1'b1;
          st_q <= StOut;
        end
        StOut: begin
          o_roll_q <= r_q[14:0]; o_pitch_q <= p_q[14:0]; o_yaw_q <= y_q[14:0];
          o_rx_q <= rx_q; o_ry_q <= ry_q; o_rz_q <= rz_q;
          o_bl_q <= blended_q; o_sd_q <= seeded_q;
          out_valid_q <= 1'b1;
          st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign roll_angle_o = o_roll_q;
  assign pitch_angle_o = o_pitch_q;
  assign yaw_angle_o = o_yaw_q;
  assign rate_x_o = o_rx_q;
  assign rate_y_o = o_ry_q;
  assign rate_z_o = o_rz_q;
  assign blend_applied_o = o_bl_q;
  assign seeded_o = o_sd_q;

endmodule
